>>> rtl/mlkcmp_pkg.sv
// shared types, constants and helpers for the coefficient compress and pack block
package mlkcmp_pkg;

  localparam int POLY_LEN    = 256;
  localparam int MODULUS     = 3329;
  localparam int IDX_W       = $clog2(POLY_LEN);

  localparam int COEFF_W     = 13;
  localparam int X_W         = 12;
  localparam int OPA_W       = 23;
  localparam int OPB_W       = 21;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int CODE_W      = 11;
  localparam int ACC_W       = 18;
  localparam int CNT_W       = 5;
  localparam int CFG_W       = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;
  localparam logic [CFG_W-1:0] CFG_D4    = 4'd4;
  localparam logic [CFG_W-1:0] CFG_D5    = 4'd5;
  localparam logic [CFG_W-1:0] CFG_D10   = 4'd10;

  localparam logic signed [COEFF_W-1:0] SAT_HI = 13'sd3328;
  localparam logic signed [COEFF_W-1:0] SAT_LO = -13'sd3328;
  localparam logic signed [COEFF_W-1:0] Q_S    = 13'sd3329;

  localparam logic [OPA_W-1:0] RND_4  = 23'd1665;
  localparam logic [OPA_W-1:0] RND_5  = 23'd1664;
  localparam logic [OPA_W-1:0] RND_10 = 23'd1665;
  localparam logic [OPA_W-1:0] RND_11 = 23'd1664;

  localparam logic [OPB_W-1:0] MUL_4  = 21'd80635;
  localparam logic [OPB_W-1:0] MUL_5  = 21'd40318;
  localparam logic [OPB_W-1:0] MUL_10 = 21'd1290167;
  localparam logic [OPB_W-1:0] MUL_11 = 21'd645084;

  typedef enum logic [1:0] {
    W4  = 2'd0,
    W5  = 2'd1,
    W10 = 2'd2,
    W11 = 2'd3
  } width_sel_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    width_sel_t        sel;
    logic              last;
  } q_entry_t;

  function automatic logic [CNT_W-1:0] sel_bits(input width_sel_t sel);
    logic [CNT_W-1:0] n;
    unique case (sel)
      W4:      n = 5'd4;
      W5:      n = 5'd5;
      W10:     n = 5'd10;
      default: n = 5'd11;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/mlkcmp_front.sv
// front end: config register, saturation, compression multiply pipeline
module mlkcmp_front import mlkcmp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COEFF_W-1:0] in_coeff_value,
  output logic                      q_push,
  output q_entry_t                  q_wdata,
  input  logic                      q_full
);

  logic [CFG_W-1:0] compress_bits_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic              s1_valid_r;
  logic [OPA_W-1:0]  s1_a_r;
  logic [OPB_W-1:0]  s1_b_r;
  width_sel_t        s1_sel_r;
  logic              s1_last_r;

  logic              s2_valid_r;
  logic [PROD_W-1:0] s2_prod_r;
  width_sel_t        s2_sel_r;
  logic              s2_last_r;

  logic                      accept, s1_move, s2_take;
  logic                      last_of_poly;
  width_sel_t                sel;
  logic signed [COEFF_W-1:0] sat, wrapped;
  logic [X_W-1:0]            x;
  logic [OPA_W-1:0]          opa, x_ext;
  logic [OPB_W-1:0]          opb;
  logic [CODE_W-1:0]         code;

  assign q_push   = s2_valid_r && !q_full;
  assign s2_take  = !s2_valid_r || q_push;
  assign s1_move  = s1_valid_r && s2_take;
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (compress_bits_r)
      CFG_D4:  sel = W4;
      CFG_D5:  sel = W5;
      CFG_D10: sel = W10;
      default: sel = W11;
    endcase
  end

  // saturate, then fold negatives into 0..q-1
  always_comb begin
    if (in_coeff_value > SAT_HI) begin
      sat = SAT_HI;
    end else if (in_coeff_value < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = in_coeff_value;
    end
    wrapped = (sat < 0) ? sat + Q_S : sat;
    x       = wrapped[X_W-1:0];
    x_ext   = OPA_W'(x);
  end

  always_comb begin
    case (sel)
      W4: begin
        opa = (x_ext << 4) + RND_4;
        opb = MUL_4;
      end
      W5: begin
        opa = (x_ext << 5) + RND_5;
        opb = MUL_5;
      end
      W10: begin
        opa = (x_ext << 10) + RND_10;
        opb = MUL_10;
      end
      default: begin
        opa = (x_ext << 11) + RND_11;
        opb = MUL_11;
      end
    endcase
  end

  assign last_of_poly = (idx_r == IDX_W'(POLY_LEN - 1));
  assign idx_nxt      = last_of_poly ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compress_bits_r <= CFG_RESET;
      idx_r           <= '0;
      s1_valid_r      <= 1'b0;
      s2_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        compress_bits_r <= cfg_wr_data;
      end
      if (accept) begin
        idx_r <= idx_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a_r    <= opa;
      s1_b_r    <= opb;
      s1_sel_r  <= sel;
      s1_last_r <= last_of_poly;
    end
    if (s1_move) begin
      s2_prod_r <= PROD_W'(s1_a_r) * PROD_W'(s1_b_r);
      s2_sel_r  <= s1_sel_r;
      s2_last_r <= s1_last_r;
    end
  end

  // fixed shift and mask per width
  always_comb begin
    case (s2_sel_r)
      W4:      code = CODE_W'(s2_prod_r[31:28]);
      W5:      code = CODE_W'(s2_prod_r[31:27]);
      W10:     code = CODE_W'(s2_prod_r[41:32]);
      default: code = s2_prod_r[41:31];
    endcase
  end

  assign q_wdata.code = code;
  assign q_wdata.sel  = s2_sel_r;
  assign q_wdata.last = s2_last_r;

endmodule

>>> rtl/mlkcmp_queue.sv
// small register queue between front end and packer
module mlkcmp_queue import mlkcmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     not_empty
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/mlkcmp_back.sv
// back end: bit accumulator and byte output register
module mlkcmp_back import mlkcmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  q_entry_t    q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_poly_done
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_run_last_r, out_poly_done_r;

  logic             out_free, emit;
  logic [ACC_W-1:0] rem_acc;
  logic [CNT_W-1:0] rem_cnt;
  logic             rem_small;

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (cnt_r >= 5'd8) && out_free;
  assign rem_acc   = emit ? (acc_r >> 8) : acc_r;
  assign rem_cnt   = emit ? (cnt_r - 5'd8) : cnt_r;
  assign rem_small = (rem_cnt < 5'd8);
  // next coefficient merges in once fewer than a byte is left
  assign q_pop     = q_not_empty && rem_small;

  always_comb begin
    acc_nxt = rem_acc;
    cnt_nxt = rem_cnt;
    if (q_pop) begin
      acc_nxt = rem_acc | (ACC_W'(q_rdata.code) << rem_cnt[2:0]);
      cnt_nxt = rem_cnt + sel_bits(q_rdata.sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      if (q_pop) begin
        last_r <= q_rdata.last;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r      <= acc_r[7:0];
      out_run_last_r  <= rem_small;
      out_poly_done_r <= rem_small && last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_poly_done = out_poly_done_r;

endmodule

>>> rtl/mlkem_coeff_compress_pack.sv
// top level of the coefficient compress and byte pack block
//
//   channel | ports                                   | direction | beat
//   --------+-----------------------------------------+-----------+-------------------------
//   in      | in_valid in_ready in_coeff_value        | input     | one signed coefficient
//   out     | out_valid out_ready out_byte            | output    | one packed byte + flags
//           | out_run_last out_poly_done              |           |
//   cfg     | cfg_wr_en cfg_wr_data                   | input     | compress width, no wait
//
// one coefficient per cycle enters the multiply pipeline while in_ready is high; the
// packer emits one byte per cycle while out is not stalled, so it keeps pace with the
// input at d=4 and d=5 but falls behind on average at d=10 and d=11
// an accepted beat passes two multiply stages, the queue, the packer and the output
// register on its way to out
// synchronous active-low reset clears pipeline, queue, bit accumulator and index
// each side stalls on its own: a stalled out fills the queue before in_ready drops
module mlkem_coeff_compress_pack import mlkcmp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COEFF_W-1:0] in_coeff_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_run_last,
  output logic                      out_poly_done
);

  logic     q_push, q_full, q_pop, q_not_empty;
  q_entry_t q_wdata, q_rdata;

  mlkcmp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coeff_value (in_coeff_value),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  mlkcmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  mlkcmp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_poly_done (out_poly_done)
  );

endmodule

>>> rtl/mlkcmp_checker.sv
// port-level checks for the compress and pack block, bound to the top level
module mlkcmp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_poly_done
);

  // reset empties the output register and opens the input
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("out_valid or in_ready wrong after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_run_last) && $stable(out_poly_done))
    else $error("output beat changed while stalled");

  // end of polynomial only on a byte that also carries run_last
  a_poly_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_poly_done |-> out_run_last)
    else $error("poly_done without run_last");

  // pipeline depth: no byte can appear before the pipeline has had time to fill after leaving reset
  a_min_latency: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("byte appeared faster than the pipeline allows");

  // a first cycle out of reset that takes no coefficient is not followed by a byte
  a_no_invented: assert property (@(posedge clk)
    !rst_n ##1 (rst_n && !(in_valid && in_ready)) |=> !out_valid)
    else $error("byte without any accepted coefficient");

endmodule

bind mlkem_coeff_compress_pack mlkcmp_checker u_mlkcmp_checker (.*);
